FILE: rtl/tea_pkg.sv
// Shared types and constants for the TEA block cipher pipeline.
`default_nettype none

package tea_pkg;

   localparam int ROUNDS = 32;
   localparam int STAGES = 2 * ROUNDS;

   localparam logic [31:0] DELTA = 32'h9e37_79b9;
   localparam logic [31:0] DEC_SUM_INIT = 32'(64'(DELTA) * ROUNDS);
   // sum left behind by the last cell: encrypt ends one delta past the last round
   localparam logic [31:0] ENC_SUM_FINAL = 32'(64'(DELTA) * (ROUNDS + 1));
   localparam logic [31:0] DEC_SUM_FINAL = 32'h0000_0000;

   localparam logic [1:0] CSR_KEY_ZERO  = 2'd0;
   localparam logic [1:0] CSR_KEY_ONE   = 2'd1;
   localparam logic [1:0] CSR_KEY_TWO   = 2'd2;
   localparam logic [1:0] CSR_KEY_THREE = 2'd3;

   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   typedef struct packed {
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
   } key_type;

   typedef struct packed {
      logic        valid;
      logic        decrypt;
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] sum;
   } stage_type;

endpackage

`default_nettype wire

FILE: rtl/tea_block_cipher.sv
// TEA block cipher top level: key registers and a chain of half-round cells.
// Each accepted word passes through the cell chain, one cell per half-round, to rsp_valid.
// Throughput: one word per cycle; the whole cell chain advances together and holds
// only while a finished word waits under rsp_stall.
// Reset: synchronous, active high; clears every cell's valid bit and the key to zero.
`default_nettype none

module tea_block_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_block_left,
   input  wire logic [31:0] req_block_right,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_left,
   output logic [31:0]      rsp_out_right,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   tea_pkg::key_type   key_ff;
   tea_pkg::key_type   key_in;
   tea_pkg::stage_type stage_link [0:tea_pkg::STAGES];
   logic [tea_pkg::STAGES-1:0] stage_valid;
   logic               advance;

   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tea_pkg::CSR_KEY_ZERO:  key_in.k0 = csr_write_data;
            tea_pkg::CSR_KEY_ONE:   key_in.k1 = csr_write_data;
            tea_pkg::CSR_KEY_TWO:   key_in.k2 = csr_write_data;
            tea_pkg::CSR_KEY_THREE: key_in.k3 = csr_write_data;
            default:                key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // hold the whole chain only while the last word is waiting
   assign advance   = !stage_link[tea_pkg::STAGES].valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      stage_link[0].valid   = req_valid;
      stage_link[0].decrypt = req_type;
      stage_link[0].left    = req_block_left;
      stage_link[0].right   = req_block_right;
      stage_link[0].sum     = (req_type == tea_pkg::REQ_DECRYPT) ? tea_pkg::DEC_SUM_INIT
                                                                 : tea_pkg::DELTA;
   end

   for (genvar i = 0; i < tea_pkg::STAGES; i++) begin : g_cell
      tea_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .odd     (1'(i % 2)),
         .key     (key_ff),
         .stage_i (stage_link[i]),
         .stage_o (stage_link[i+1])
      );
      assign stage_valid[i] = stage_link[i+1].valid;
   end

   assign rsp_valid     = stage_link[tea_pkg::STAGES].valid;
   assign rsp_out_left  = stage_link[tea_pkg::STAGES].left;
   assign rsp_out_right = stage_link[tea_pkg::STAGES].right;

   // an accepted word lands in the first cell
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid[0])
      else $error("accepted word did not enter the first cell");

   // a stalled result freezes every cell's occupancy
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(stage_valid))
      else $error("cell chain moved while the result was stalled");

   // the running sum must have walked the full schedule by the last cell
   a_sum_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((stage_link[tea_pkg::STAGES].decrypt == tea_pkg::REQ_DECRYPT)
         ? (stage_link[tea_pkg::STAGES].sum == tea_pkg::DEC_SUM_FINAL)
         : (stage_link[tea_pkg::STAGES].sum == tea_pkg::ENC_SUM_FINAL)))
      else $error("key schedule sum out of step at the last cell");

   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_write_enable |=> $stable(key_ff))
      else $error("key changed without a register write");

endmodule

`default_nettype wire

FILE: rtl/tea_cell.sv
// One half-round cell of the TEA pipeline: updates one half of the word.
`default_nettype none

module tea_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                odd,
   input  wire tea_pkg::key_type    key,
   input  wire tea_pkg::stage_type  stage_i,
   output tea_pkg::stage_type       stage_o
);

   logic        valid_ff;
   logic        valid_in;
   logic        decrypt_ff;
   logic [31:0] left_ff;
   logic [31:0] right_ff;
   logic [31:0] sum_ff;
   logic [31:0] left_in;
   logic [31:0] right_in;
   logic [31:0] sum_in;

   logic        upd_left;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] mix;
   logic [31:0] dst_new;

   // encrypt updates left on even cells, decrypt on odd cells
   assign upd_left = odd ~^ stage_i.decrypt;

   always_comb begin
      src = upd_left ? stage_i.right : stage_i.left;
      dst = upd_left ? stage_i.left : stage_i.right;
      ka  = upd_left ? key.k0 : key.k2;
      kb  = upd_left ? key.k1 : key.k3;
      mix = ((src << 4) + ka) ^ (src + stage_i.sum) ^ ((src >> 5) + kb);
      dst_new = stage_i.decrypt ? (dst - mix) : (dst + mix);
      left_in  = upd_left ? dst_new : stage_i.left;
      right_in = upd_left ? stage_i.right : dst_new;
      // step the sum after the second half of each round
      sum_in = stage_i.sum;
      if (odd) begin
         sum_in = stage_i.decrypt ? (stage_i.sum - tea_pkg::DELTA)
                                  : (stage_i.sum + tea_pkg::DELTA);
      end
      valid_in = stage_i.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         decrypt_ff <= stage_i.decrypt;
         left_ff    <= left_in;
         right_ff   <= right_in;
         sum_ff     <= sum_in;
      end
   end

   assign stage_o.valid   = valid_ff;
   assign stage_o.decrypt = decrypt_ff;
   assign stage_o.left    = left_ff;
   assign stage_o.right   = right_ff;
   assign stage_o.sum     = sum_ff;

endmodule

`default_nettype wire
